// File: sv/matrix4_column_multiplier_unit_defines.svh
// Assertion macros shared by the matrix column multiplier modules.
`ifndef MATRIX4_COLUMN_MULTIPLIER_UNIT_DEFINES_SVH
`define MATRIX4_COLUMN_MULTIPLIER_UNIT_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define MCM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define MCM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/mcm_pkg.sv
// Shared constants and types of the matrix column multiplier.
`timescale 1ns / 1ps

package mcm_pkg;

   // Matrix size and fixed-point format.
   localparam int DIM       = 4;
   localparam int FRAC_BITS = 16;
   localparam int NUM_ELEMS = 4;
   localparam int DATA_W    = 32;
   localparam int COL_W     = 2;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int ACC_W     = PROD_W + $clog2(DIM);
   localparam int CELL_W    = $clog2(DIM);
   localparam int IDX_W     = (CELL_W > COL_W) ? CELL_W : COL_W;

   // Request commands.
   typedef enum logic {
      CMD_LOAD     = 1'b0,
      CMD_MULTIPLY = 1'b1
   } cmd_type;

   typedef logic [DATA_W-1:0] word_type;

   // One request as it travels down the chain.
   typedef struct packed {
      logic                         valid;
      cmd_type                      cmd;
      logic [COL_W-1:0]             col;
      word_type [NUM_ELEMS-1:0]     elems;
   } item_type;

   // Request plus the partial row sums formed so far.
   typedef struct packed {
      item_type                     item;
      logic [DIM-1:0][ACC_W-1:0]    acc;
   } stage_type;

endpackage

// File: sv/mcm_cell.sv
// One chain cell: holds one left-matrix column and adds its products to the row sums.
`timescale 1ns / 1ps
`include "matrix4_column_multiplier_unit_defines.svh"

module mcm_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [mcm_pkg::IDX_W-1:0]     cell_id,
   input  mcm_pkg::stage_type            chain_in,
   output mcm_pkg::stage_type            chain_out
);

   mcm_pkg::word_type [mcm_pkg::DIM-1:0]                   col_ff;
   mcm_pkg::word_type [mcm_pkg::DIM-1:0]                   col_in;
   mcm_pkg::word_type [mcm_pkg::DIM-1:0]                   load_col;
   mcm_pkg::word_type                                      b_word;
   logic                                                   load_hit;
   mcm_pkg::item_type                                      item1_ff;
   logic [mcm_pkg::DIM-1:0][mcm_pkg::ACC_W-1:0]            acc1_ff;
   logic [mcm_pkg::DIM-1:0][mcm_pkg::PROD_W-1:0]           prod_ff;
   logic [mcm_pkg::DIM-1:0][mcm_pkg::PROD_W-1:0]           prod_in;
   mcm_pkg::stage_type                                     out_ff;
   mcm_pkg::stage_type                                     out_in;

   // Pick the element of the right column that meets this cell's column.
   always_comb begin
      b_word = '0;
      for (int e = 0; e < mcm_pkg::NUM_ELEMS; e++) begin
         if (cell_id == mcm_pkg::IDX_W'(e)) begin
            b_word = chain_in.item.elems[e];
         end
      end
   end

   // A load request whose column matches this cell replaces the stored column.
   always_comb begin
      for (int r = 0; r < mcm_pkg::DIM; r++) begin
         if (r < mcm_pkg::NUM_ELEMS) begin
            load_col[r] = chain_in.item.elems[r];
         end else begin
            load_col[r] = '0;
         end
      end
      load_hit = advance && chain_in.item.valid &&
                 (chain_in.item.cmd == mcm_pkg::CMD_LOAD) &&
                 (mcm_pkg::IDX_W'(chain_in.item.col) == cell_id);
      col_in   = load_hit ? load_col : col_ff;
   end

   // First stage: one signed 32 by 32 product per row.
   always_comb begin
      for (int r = 0; r < mcm_pkg::DIM; r++) begin
         prod_in[r] = $signed(col_ff[r]) * $signed(b_word);
      end
   end

   // Second stage: add the products to the incoming row sums.
   always_comb begin
      out_in.item = item1_ff;
      for (int r = 0; r < mcm_pkg::DIM; r++) begin
         out_in.acc[r] = acc1_ff[r] + mcm_pkg::ACC_W'($signed(prod_ff[r]));
      end
   end

   // Stage registers; the whole chain holds while the result is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff            <= '0;
         item1_ff.valid    <= 1'b0;
         out_ff.item.valid <= 1'b0;
      end else begin
         col_ff <= col_in;
         if (advance) begin
            item1_ff <= chain_in.item;
            acc1_ff  <= chain_in.acc;
            prod_ff  <= prod_in;
            out_ff   <= out_in;
         end
      end
   end

   assign chain_out = out_ff;

   `MCM_ASSERT_NEXT(a_cell_hold, !advance, $stable(chain_out), "cell moved during a stall")
   `MCM_ASSERT_NEXT(a_cell_load, load_hit, col_ff == $past(load_col), "column load was lost")

endmodule

// File: sv/mcm_clamp.sv
// Final stage: shifts the row sums, saturates them and holds the result.
`timescale 1ns / 1ps
`include "matrix4_column_multiplier_unit_defines.svh"

module mcm_clamp (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           advance,
   input  mcm_pkg::stage_type                             chain_in,
   output logic                                           rsp_valid,
   output logic [mcm_pkg::COL_W-1:0]                      rsp_column,
   output mcm_pkg::word_type [mcm_pkg::NUM_ELEMS-1:0]     rsp_res,
   output logic                                           rsp_saturated
);

   localparam mcm_pkg::word_type WORD_MAX = {1'b0, {(mcm_pkg::DATA_W - 1){1'b1}}};
   localparam mcm_pkg::word_type WORD_MIN = ~WORD_MAX;

   logic [mcm_pkg::DIM-1:0][mcm_pkg::ACC_W-1:0]        shifted;
   logic [mcm_pkg::DIM-1:0]                            row_fits;
   mcm_pkg::word_type [mcm_pkg::DIM-1:0]               row_val;
   mcm_pkg::word_type [mcm_pkg::NUM_ELEMS-1:0]         res_in;
   logic                                               sat_in;
   logic                                               valid_in;
   logic                                               rsp_valid_ff;
   logic [mcm_pkg::COL_W-1:0]                          rsp_column_ff;
   mcm_pkg::word_type [mcm_pkg::NUM_ELEMS-1:0]         rsp_res_ff;
   logic                                               rsp_sat_ff;
   logic                                               any_limit;

   // Arithmetic shift by the fraction bits, then clamp to 32 bits.
   always_comb begin
      sat_in = 1'b0;
      for (int r = 0; r < mcm_pkg::DIM; r++) begin
         shifted[r]  = mcm_pkg::ACC_W'($signed(chain_in.acc[r]) >>> mcm_pkg::FRAC_BITS);
         row_fits[r] = (&shifted[r][mcm_pkg::ACC_W-1:mcm_pkg::DATA_W-1]) ||
                       !(|shifted[r][mcm_pkg::ACC_W-1:mcm_pkg::DATA_W-1]);
         if (row_fits[r]) begin
            row_val[r] = shifted[r][mcm_pkg::DATA_W-1:0];
         end else if (shifted[r][mcm_pkg::ACC_W-1]) begin
            row_val[r] = WORD_MIN;
         end else begin
            row_val[r] = WORD_MAX;
         end
         sat_in = sat_in | !row_fits[r];
      end
   end

   // Rows beyond the matrix size read as zero.
   always_comb begin
      for (int r = 0; r < mcm_pkg::NUM_ELEMS; r++) begin
         if (r < mcm_pkg::DIM) begin
            res_in[r] = row_val[r];
         end else begin
            res_in[r] = '0;
         end
      end
      valid_in = chain_in.item.valid && (chain_in.item.cmd == mcm_pkg::CMD_MULTIPLY);
   end

   // Output register; only multiply requests give a result.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff  <= valid_in;
         rsp_column_ff <= chain_in.item.col;
         rsp_res_ff    <= res_in;
         rsp_sat_ff    <= sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_column    = rsp_column_ff;
   assign rsp_res       = rsp_res_ff;
   assign rsp_saturated = rsp_sat_ff;

   // A saturated result must show at least one clamped element.
   always_comb begin
      any_limit = 1'b0;
      for (int r = 0; r < mcm_pkg::NUM_ELEMS; r++) begin
         any_limit = any_limit | (rsp_res_ff[r] == WORD_MAX) | (rsp_res_ff[r] == WORD_MIN);
      end
   end

   `MCM_ASSERT_NOW(a_sat_limit, rsp_valid_ff && rsp_sat_ff, any_limit, "flag without clamp")
   `MCM_ASSERT_NEXT(a_load_silent, advance && chain_in.item.valid && chain_in.item.cmd == mcm_pkg::CMD_LOAD, !rsp_valid_ff, "load gave a result")

endmodule

// File: sv/matrix4_column_multiplier_unit.sv
// Top level of the fixed-point 4x4 column-major matrix column multiplier.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_ready   command, column, elem_0..elem_3
//   rsp      out        rsp_valid/rsp_ready   out_column, res_0..res_3, saturated
//
// One request is taken every cycle unless a result waits for rsp_ready; a
// multiply result passes two register stages per chain cell and then the clamp
// register, the first of them loaded at the edge that accepts its request.
// Loads travel down the chain in order and write their cell as they pass it.
// Reset clears the stored left matrix and the stage valid bits.
// While a result waits for rsp_ready the whole chain holds and req_ready is low.
`timescale 1ns / 1ps

module matrix4_column_multiplier_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_command,
   input  logic [mcm_pkg::COL_W-1:0]             req_column,
   input  logic signed [mcm_pkg::DATA_W-1:0]     req_elem_0,
   input  logic signed [mcm_pkg::DATA_W-1:0]     req_elem_1,
   input  logic signed [mcm_pkg::DATA_W-1:0]     req_elem_2,
   input  logic signed [mcm_pkg::DATA_W-1:0]     req_elem_3,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [mcm_pkg::COL_W-1:0]             rsp_out_column,
   output logic signed [mcm_pkg::DATA_W-1:0]     rsp_res_0,
   output logic signed [mcm_pkg::DATA_W-1:0]     rsp_res_1,
   output logic signed [mcm_pkg::DATA_W-1:0]     rsp_res_2,
   output logic signed [mcm_pkg::DATA_W-1:0]     rsp_res_3,
   output logic                                  rsp_saturated
);

   mcm_pkg::stage_type                             chain [mcm_pkg::DIM+1];
   mcm_pkg::word_type [mcm_pkg::NUM_ELEMS-1:0]     rsp_res;
   logic                                           advance;

   // The chain moves whenever the output register is free or being emptied.
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // Entry of the chain: the incoming request with empty row sums.
   always_comb begin
      chain[0].item.valid    = req_valid;
      chain[0].item.cmd      = mcm_pkg::cmd_type'(req_command);
      chain[0].item.col      = req_column;
      chain[0].item.elems[0] = req_elem_0;
      chain[0].item.elems[1] = req_elem_1;
      chain[0].item.elems[2] = req_elem_2;
      chain[0].item.elems[3] = req_elem_3;
      chain[0].acc           = '0;
   end

   // One cell per left-matrix column.
   for (genvar k = 0; k < mcm_pkg::DIM; k++) begin : g_cell
      mcm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .cell_id   (mcm_pkg::IDX_W'(k)),
         .chain_in  (chain[k]),
         .chain_out (chain[k+1])
      );
   end

   // Shift, saturate and hold the result.
   mcm_clamp u_clamp (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .chain_in      (chain[mcm_pkg::DIM]),
      .rsp_valid     (rsp_valid),
      .rsp_column    (rsp_out_column),
      .rsp_res       (rsp_res),
      .rsp_saturated (rsp_saturated)
   );

   assign rsp_res_0 = rsp_res[0];
   assign rsp_res_1 = rsp_res[1];
   assign rsp_res_2 = rsp_res[2];
   assign rsp_res_3 = rsp_res[3];

endmodule

// File: dv/matrix4_column_multiplier_unit_test.sv
// Self-checking testbench for the 4x4 fixed-point matrix column multiplier.
`timescale 1ns / 1ps

module matrix4_column_multiplier_unit_test;

   typedef logic [mcm_pkg::NUM_ELEMS-1:0][mcm_pkg::DATA_W-1:0] elem_vec_type;

   // One product column as it should leave the block.
   typedef struct packed {
      logic [mcm_pkg::COL_W-1:0] column;
      elem_vec_type              res;
      logic                      saturated;
   } product_column_type;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 4 * mcm_pkg::DIM;
   localparam int PHASE_ITEMS    = 370;

   localparam logic signed [127:0] WORD_MAX = 128'sd2147483647;
   localparam logic signed [127:0] WORD_MIN = -128'sd2147483648;

   localparam logic [mcm_pkg::DATA_W-1:0] Q_ONE   = 32'h0001_0000;
   localparam logic [mcm_pkg::DATA_W-1:0] Q_HALF  = 32'h0000_8000;
   localparam logic [mcm_pkg::DATA_W-1:0] RAW_MAX = 32'h7FFF_FFFF;
   localparam logic [mcm_pkg::DATA_W-1:0] RAW_MIN = 32'h8000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_valid   = 1'b0;
   logic                                req_ready;
   logic                                req_command = 1'b0;
   logic [mcm_pkg::COL_W-1:0]           req_column  = '0;
   logic signed [mcm_pkg::DATA_W-1:0]   req_elem_0  = '0;
   logic signed [mcm_pkg::DATA_W-1:0]   req_elem_1  = '0;
   logic signed [mcm_pkg::DATA_W-1:0]   req_elem_2  = '0;
   logic signed [mcm_pkg::DATA_W-1:0]   req_elem_3  = '0;
   logic                                rsp_valid;
   logic                                rsp_ready   = 1'b0;
   logic [mcm_pkg::COL_W-1:0]           rsp_out_column;
   logic signed [mcm_pkg::DATA_W-1:0]   rsp_res_0;
   logic signed [mcm_pkg::DATA_W-1:0]   rsp_res_1;
   logic signed [mcm_pkg::DATA_W-1:0]   rsp_res_2;
   logic signed [mcm_pkg::DATA_W-1:0]   rsp_res_3;
   logic                                rsp_saturated;

   // Predicted copy of the stored left matrix, column-major.
   logic signed [mcm_pkg::DATA_W-1:0] left_cells [mcm_pkg::DIM*mcm_pkg::DIM] =
      '{default: '0};
   product_column_type                pending_products [$];

   int error_count   = 0;
   int idle_cycles   = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int sets_sent     = 0;
   int requests_sent = 0;

   matrix4_column_multiplier_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_column     (req_column),
      .req_elem_0     (req_elem_0),
      .req_elem_1     (req_elem_1),
      .req_elem_2     (req_elem_2),
      .req_elem_3     (req_elem_3),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_column (rsp_out_column),
      .rsp_res_0      (rsp_res_0),
      .rsp_res_1      (rsp_res_1),
      .rsp_res_2      (rsp_res_2),
      .rsp_res_3      (rsp_res_3),
      .rsp_saturated  (rsp_saturated)
   );

   always #5 clock = ~clock;

   // Receiver back-pressure, redrawn every cycle.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Print one failure line and count it.
   task automatic report_error(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic elem_vec_type column_of(logic [mcm_pkg::DATA_W-1:0] e0,
                                              logic [mcm_pkg::DATA_W-1:0] e1,
                                              logic [mcm_pkg::DATA_W-1:0] e2,
                                              logic [mcm_pkg::DATA_W-1:0] e3);
      return {e3, e2, e1, e0};
   endfunction

   // Apply one accepted request to the predicted matrix, or queue the product
   // column that it should produce. Each row sum is exact, then floored by the
   // fraction shift and clamped to 32 bits.
   function automatic void predict_request(mcm_pkg::cmd_type cmd,
                                           logic [mcm_pkg::COL_W-1:0] col,
                                           elem_vec_type elems);
      product_column_type  prod;
      logic signed [127:0] acc;
      logic signed [127:0] lhs;
      logic signed [127:0] rhs;
      if (cmd == mcm_pkg::CMD_LOAD) begin
         // A load to a column past the matrix size changes nothing.
         if (int'(col) < mcm_pkg::DIM) begin
            for (int r = 0; r < mcm_pkg::DIM; r++) begin
               left_cells[int'(col) * mcm_pkg::DIM + r] = elems[r];
            end
         end
         return;
      end
      prod.column    = col;
      prod.saturated = 1'b0;
      for (int r = 0; r < mcm_pkg::NUM_ELEMS; r++) begin
         acc = '0;
         for (int k = 0; k < mcm_pkg::DIM; k++) begin
            lhs = left_cells[k * mcm_pkg::DIM + r];
            rhs = $signed(elems[k]);
            acc = acc + lhs * rhs;
         end
         acc = acc >>> mcm_pkg::FRAC_BITS;
         if (acc > WORD_MAX) begin
            prod.res[r]    = WORD_MAX[mcm_pkg::DATA_W-1:0];
            prod.saturated = 1'b1;
         end else if (acc < WORD_MIN) begin
            prod.res[r]    = WORD_MIN[mcm_pkg::DATA_W-1:0];
            prod.saturated = 1'b1;
         end else begin
            prod.res[r] = acc[mcm_pkg::DATA_W-1:0];
         end
      end
      pending_products.push_back(prod);
   endfunction

   // Offer one request, with random idle cycles first, and wait for its acceptance.
   task automatic send_request(mcm_pkg::cmd_type cmd, logic [mcm_pkg::COL_W-1:0] col,
                               elem_vec_type elems);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_column  <= col;
      req_elem_0  <= elems[0];
      req_elem_1  <= elems[1];
      req_elem_2  <= elems[2];
      req_elem_3  <= elems[3];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_request(cmd, col, elems);
      requests_sent++;
   endtask

   // Hold the sender off until every product column has come back.
   task automatic wait_for_products();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_products.size() != 0) @(posedge clock);
   endtask

   // Element values: small Q16.16 numbers most often, plus full-range words,
   // mid-size values that overflow now and then, and the corner words.
   function automatic logic [mcm_pkg::DATA_W-1:0] random_element();
      case ($urandom_range(9))
         0, 1, 2, 3: return $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
         4, 5, 6:    return $urandom();
         7: begin
            case ($urandom_range(6))
               0:       return '0;
               1:       return 32'h0000_0001;
               2:       return 32'hFFFF_FFFF;
               3:       return RAW_MAX;
               4:       return RAW_MIN;
               5:       return Q_ONE;
               default: return -Q_ONE;
            endcase
         end
         default:    return $urandom_range(32'h01FF_FFFF) - 32'h0100_0000;
      endcase
   endfunction

   function automatic elem_vec_type random_column();
      return column_of(random_element(), random_element(), random_element(),
                       random_element());
   endfunction

   // Stream matrix sets: most are column loads followed by a few multiplies,
   // the rest are lone requests with random command and column.
   task automatic run_stream(int n_items, int idle_pct, int stall_percent);
      int first_col;
      int n_loads;
      int n_mults;
      int stop_at;
      send_idle_pct = idle_pct;
      stall_pct     = stall_percent;
      stop_at       = requests_sent + n_items;
      while (requests_sent < stop_at) begin
         if ($urandom_range(99) < 80) begin
            first_col = $urandom_range(mcm_pkg::DIM - 1);
            n_loads   = ($urandom_range(3) == 0) ? $urandom_range(1, mcm_pkg::DIM - 1)
                                                 : mcm_pkg::DIM;
            n_mults   = $urandom_range(1, 6);
            for (int i = 0; i < n_loads; i++) begin
               send_request(mcm_pkg::CMD_LOAD,
                            mcm_pkg::COL_W'((first_col + i) % mcm_pkg::DIM),
                            random_column());
            end
            for (int i = 0; i < n_mults; i++) begin
               send_request(mcm_pkg::CMD_MULTIPLY,
                            mcm_pkg::COL_W'($urandom_range(mcm_pkg::DIM - 1)),
                            random_column());
            end
         end else begin
            send_request(mcm_pkg::cmd_type'($urandom_range(1)),
                         mcm_pkg::COL_W'($urandom_range(3)), random_column());
         end
         sets_sent++;
         if (sets_sent == 3 || $urandom_range(24) == 0) wait_for_products();
      end
   endtask

   // Reset contents, identity, exact limits, overflow both ways and floor rounding.
   task automatic test_reset_and_extremes();
      send_idle_pct = 0;
      stall_pct     = 0;
      // The left matrix is zero after reset.
      send_request(mcm_pkg::CMD_MULTIPLY, 2'd0,
                   column_of(Q_ONE, RAW_MAX, RAW_MIN, 32'hFFFF_FFFF));
      // Identity passes the right column through unchanged.
      for (int c = 0; c < mcm_pkg::DIM; c++) begin
         send_request(mcm_pkg::CMD_LOAD, mcm_pkg::COL_W'(c),
                      column_of((c == 0) ? Q_ONE : '0, (c == 1) ? Q_ONE : '0,
                                (c == 2) ? Q_ONE : '0, (c == 3) ? Q_ONE : '0));
      end
      send_request(mcm_pkg::CMD_MULTIPLY, 2'd1,
                   column_of(RAW_MAX, RAW_MIN, 32'd1, 32'hFFFF_FFFF));
      send_request(mcm_pkg::CMD_MULTIPLY, 2'd3, column_of('0, '0, '0, '0));
      // Largest words everywhere overflow in both directions.
      for (int c = 0; c < mcm_pkg::DIM; c++) begin
         send_request(mcm_pkg::CMD_LOAD, mcm_pkg::COL_W'(c),
                      column_of(RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX));
      end
      send_request(mcm_pkg::CMD_MULTIPLY, 2'd2, column_of(RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX));
      send_request(mcm_pkg::CMD_MULTIPLY, 2'd0, column_of(RAW_MIN, RAW_MIN, RAW_MIN, RAW_MIN));
      send_request(mcm_pkg::CMD_MULTIPLY, 2'd1, column_of(32'd1, '0, '0, '0));
      // A small negative product floors toward minus infinity.
      send_request(mcm_pkg::CMD_MULTIPLY, 2'd3, column_of(32'hFFFF_FFFF, '0, '0, '0));
      // Results that land exactly on the limits, next to ones just beyond.
      send_request(mcm_pkg::CMD_LOAD, 2'd0, column_of(Q_ONE, 32'h0002_0000, -Q_ONE, Q_HALF));
      for (int c = 1; c < mcm_pkg::DIM; c++) begin
         send_request(mcm_pkg::CMD_LOAD, mcm_pkg::COL_W'(c), column_of('0, '0, '0, '0));
      end
      send_request(mcm_pkg::CMD_MULTIPLY, 2'd2, column_of(RAW_MAX, '0, '0, '0));
      send_request(mcm_pkg::CMD_MULTIPLY, 2'd0, column_of(RAW_MIN, '0, '0, '0));
      // The most negative word squared overflows positive.
      send_request(mcm_pkg::CMD_LOAD, 2'd0, column_of(RAW_MIN, RAW_MIN, RAW_MIN, RAW_MIN));
      send_request(mcm_pkg::CMD_MULTIPLY, 2'd3, column_of(RAW_MIN, Q_ONE, '0, '0));
      wait_for_products();
   endtask

   task automatic test_stream_no_idle();
      run_stream(PHASE_ITEMS, 0, 0);
   endtask

   task automatic test_stream_sender_idle();
      run_stream(PHASE_ITEMS, 57, 0);
   endtask

   task automatic test_stream_receiver_stall();
      run_stream(PHASE_ITEMS, 0, 57);
   endtask

   task automatic test_stream_both_idle();
      run_stream(PHASE_ITEMS, 28, 28);
   endtask

   // Compare each accepted product column with the oldest prediction.
   always @(posedge clock) begin
      product_column_type want;
      elem_vec_type       got_res;
      if (!reset && rsp_valid && rsp_ready) begin
         got_res = {rsp_res_3, rsp_res_2, rsp_res_1, rsp_res_0};
         if (pending_products.size() == 0) begin
            report_error($sformatf("result for column %0d with no multiply pending",
                                   rsp_out_column));
         end else begin
            want = pending_products.pop_front();
            if (rsp_out_column !== want.column) begin
               report_error($sformatf("out_column: expected %0d, got %0d",
                                      want.column, rsp_out_column));
            end
            for (int r = 0; r < mcm_pkg::NUM_ELEMS; r++) begin
               if (got_res[r] !== want.res[r]) begin
                  report_error($sformatf("res_%0d: expected %h, got %h",
                                         r, want.res[r], got_res[r]));
               end
            end
            if (rsp_saturated !== want.saturated) begin
               report_error($sformatf("saturated: expected %b, got %b",
                                      want.saturated, rsp_saturated));
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a request or result.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_and_extremes();
      test_stream_no_idle();
      test_stream_sender_idle();
      test_stream_receiver_stall();
      test_stream_both_idle();
      wait_for_products();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_products.size() != 0) begin
         report_error($sformatf("%0d product columns never arrived",
                                pending_products.size()));
      end
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
